// ===== rtl/swc_pkg.sv =====
// Shared types, constants and the color weight table of the slanted window match cost unit.
// No dependencies; every other file imports this package.
package swc_pkg;

	// image store geometry and channel count
	localparam int MAX_WIDTH = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_WINDOW = 15;
	localparam int CHANNELS = 3;
	localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int PIX_W = CHANNELS * 16;

	// weight table: exp(-k/16) in Q1.16
	localparam int WEIGHT_ENTRIES = 256;
	localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

	// divider quotient widths for the weight index and the final cost
	localparam int DIV_NUM_W = 60;
	localparam int DIV_DEN_W = 35;
	localparam int QUO_W = 26;
	localparam logic [4:0] WIDX_BITS = 5'd8;
	localparam logic [4:0] COST_BITS = 5'd26;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 3'd0,
		CFG_IMAGE_HEIGHT = 3'd1,
		CFG_WINDOW_SIZE  = 3'd2,
		CFG_COLOR_SIGMA  = 3'd3,
		CFG_MAX_DIST     = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		REQ_LOAD_FIRST  = 2'd0,
		REQ_LOAD_SECOND = 2'd1,
		REQ_QUERY       = 2'd2
	} req_code_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
		logic signed [15:0] chan_l;
		logic signed [15:0] chan_a;
		logic signed [15:0] chan_b;
		logic signed [31:0] plane_offset;
		logic signed [31:0] plane_slope_x;
		logic signed [31:0] plane_slope_y;
	} req_t;

	typedef struct packed {
		logic [31:0] match_cost;
		logic no_support;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic centre_rd;
		logic centre_cap;
		logic pix_rd;
		logic pix_eval;
		logic v0_rd;
		logic v1_rd;
		logic wdiv_start;
		logic w_cap;
		logic ch_mul;
		logic ch_mag;
		logic ch_wmul;
		logic ch_acc;
		logic win_step;
		logic fdiv_start;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_bounds;
		logic dst_ok;
		logic w_live;
		logic div_busy;
		logic last_chan;
		logic last_pix;
		logic tw_zero;
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CEN_RD,
		S_CEN_CAP,
		S_PIX_RD,
		S_PIX_EVAL,
		S_PIX_CHK,
		S_RD_V1,
		S_WDIV,
		S_CH_MUL,
		S_CH_MAG,
		S_CH_WMUL,
		S_CH_ACC,
		S_STEP,
		S_FIN,
		S_FDIV,
		S_DONE
	} state_t;

	typedef logic [16:0] weight_t;
	typedef weight_t weight_tab_t [WEIGHT_ENTRIES];

	// exp table built at elaboration by repeated Q32 multiplication
	function automatic weight_tab_t build_weights();
		weight_tab_t tab;
		logic [63:0] e;
		logic [63:0] r;
		e = 64'd1 << 32;
		for (int k = 0; k < WEIGHT_ENTRIES; k++) begin
			r = (e + 64'd32768) >> 16;
			tab[k] = r[16:0];
			e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
		end
		return tab;
	endfunction

	localparam weight_tab_t WEIGHT_LUT = build_weights();

endpackage

// ===== rtl/swc_req_if.sv =====
// Request channel of the match cost unit: valid, ready and one request word.
// Depends on swc_pkg for the payload type.
interface swc_req_if import swc_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/swc_rsp_if.sv =====
// Result channel of the match cost unit: valid, ready and one cost word.
// Depends on swc_pkg for the payload type.
interface swc_rsp_if import swc_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/swc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on swc_pkg; used by swc_dp for the weight index and the final cost.
module swc_div import swc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	input  logic [4:0]           nbits,
	output logic                 busy,
	output logic [QUO_W-1:0]     quo
);

	logic [DIV_NUM_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] dq_q;
	logic [QUO_W-1:0]     quo_q;
	logic [4:0]           cnt_q;
	logic                 fits;

	assign fits = rem_q >= dq_q;
	assign busy = cnt_q != 5'd0;
	assign quo = quo_q;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else if (start) begin
			cnt_q <= nbits;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	// remainder, shifted divisor and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dq_q <= DIV_NUM_W'(den) << (nbits - 5'd1);
			quo_q <= '0;
		end else if (busy) begin
			if (fits) begin
				rem_q <= rem_q - dq_q;
			end
			dq_q <= dq_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

endmodule

// ===== rtl/swc_dp.sv =====
// Datapath of the match cost unit: image stores, window counters, multipliers,
// accumulators, config registers and the result register. Depends on swc_pkg, swc_div.
module swc_dp import swc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               st,
	input  req_t                  req_data,
	output rsp_t                  rsp_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// config registers
	logic [8:0]  width_q, height_q;
	logic [3:0]  wsize_q;
	logic [15:0] sigma_q, maxd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256;
			height_q <= 9'd256;
			wsize_q <= 4'd7;
			sigma_q <= 16'd2560;
			maxd_q <= 16'd2560;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_IMAGE_WIDTH:  width_q <= cfg_data[8:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data[8:0];
				CFG_WINDOW_SIZE:  wsize_q <= cfg_data[3:0];
				CFG_COLOR_SIGMA:  sigma_q <= cfg_data;
				CFG_MAX_DIST:     maxd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [8:0]  w_eff, h_eff;
	logic [3:0]  ws_eff, span;
	logic [15:0] sigma_eff;

	assign w_eff = (width_q > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_q;
	assign h_eff = (height_q > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_q;
	assign ws_eff = (wsize_q > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : wsize_q;
	assign span = {ws_eff[3:1], 1'b0};
	assign sigma_eff = (sigma_q == 16'd0) ? 16'd1 : sigma_q;

	// query registers
	logic [7:0]         cx_q, cy_q;
	logic signed [31:0] off_q, slx_q, sly_q;

	always_ff @(posedge clk) begin
		if (cmd.accept && req_data.req_type == REQ_QUERY) begin
			cx_q <= req_data.pixel_x;
			cy_q <= req_data.pixel_y;
			off_q <= req_data.plane_offset;
			slx_q <= req_data.plane_slope_x;
			sly_q <= req_data.plane_slope_y;
		end
	end

	// window counters and channel counter
	logic [3:0] dxc_q, dyc_q;
	logic [1:0] ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dxc_q <= 4'd0;
			dyc_q <= 4'd0;
			ch_q <= 2'd0;
		end else begin
			if (cmd.accept) begin
				dxc_q <= 4'd0;
				dyc_q <= 4'd0;
			end else if (cmd.win_step) begin
				if (dxc_q == span) begin
					dxc_q <= 4'd0;
					dyc_q <= dyc_q + 4'd1;
				end else begin
					dxc_q <= dxc_q + 4'd1;
				end
			end
			if (cmd.w_cap) begin
				ch_q <= 2'd0;
			end else if (cmd.ch_acc) begin
				ch_q <= ch_q + 2'd1;
			end
		end
	end

	logic signed [9:0] px, py;

	assign px = $signed({2'b00, cx_q}) - $signed({7'd0, ws_eff[3:1]}) + $signed({6'd0, dxc_q});
	assign py = $signed({2'b00, cy_q}) - $signed({7'd0, ws_eff[3:1]}) + $signed({6'd0, dyc_q});

	// image stores
	logic [PIX_W-1:0]  img1 [MAX_WIDTH*MAX_HEIGHT];
	logic [PIX_W-1:0]  img2 [MAX_WIDTH*MAX_HEIGHT];
	logic [PIX_W-1:0]  rd1_q, rd2_q, v0_q, pix_in;
	logic [ADDR_W-1:0] wr_addr, rd1_addr, rd2_addr;
	logic [7:0]        ix, ix1;
	logic [8:0]        ix_nx;

	assign pix_in = {req_data.chan_b, req_data.chan_a, req_data.chan_l};
	assign wr_addr = {req_data.pixel_y, req_data.pixel_x};
	assign rd1_addr = cmd.centre_rd ? {cy_q, cx_q} : {py[7:0], px[7:0]};
	assign rd2_addr = cmd.v0_rd ? {py[7:0], ix} : {py[7:0], ix1};

	always_ff @(posedge clk) begin
		if (cmd.accept && req_data.req_type == REQ_LOAD_FIRST) begin
			img1[wr_addr] <= pix_in;
		end
		if (cmd.centre_rd || cmd.pix_rd) begin
			rd1_q <= img1[rd1_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && req_data.req_type == REQ_LOAD_SECOND) begin
			img2[wr_addr] <= pix_in;
		end
		if (cmd.v0_rd || cmd.v1_rd) begin
			rd2_q <= img2[rd2_addr];
		end
		if (cmd.v1_rd) begin
			v0_q <= rd2_q;
		end
	end

	// centre pixel
	logic [PIX_W-1:0] ctr_q;

	always_ff @(posedge clk) begin
		if (cmd.centre_cap) begin
			ctr_q <= rd1_q;
		end
	end

	// plane products, then target column and color distance
	logic signed [41:0] prodx_s1, prody_s1;
	logic signed [44:0] dst_q, dst_sum;
	logic [18:0]        d_q, d_sum;
	logic signed [16:0] cdiff;

	always_comb begin
		d_sum = 19'd0;
		for (int c = 0; c < CHANNELS; c++) begin
			cdiff = 17'($signed(rd1_q[c*16 +: 16])) - 17'($signed(ctr_q[c*16 +: 16]));
			d_sum = d_sum + 19'(cdiff[16] ? 17'(-cdiff) : 17'(cdiff));
		end
	end

	assign dst_sum = $signed({{19{px[9]}}, px, 16'd0}) + 45'(off_q) + 45'(prodx_s1)
		+ 45'(prody_s1);

	always_ff @(posedge clk) begin
		if (cmd.pix_rd) begin
			prodx_s1 <= slx_q * px;
			prody_s1 <= sly_q * py;
		end
		if (cmd.pix_eval) begin
			dst_q <= dst_sum;
			d_q <= d_sum;
		end
	end

	assign ix = dst_q[23:16];
	assign ix_nx = {1'b0, ix} + 9'd1;
	assign ix1 = (ix_nx < w_eff) ? ix_nx[7:0] : 8'(w_eff - 9'd1);

	// shared divider
	logic [DIV_NUM_W-1:0] ssd_q;
	logic [26:0]          tw_q;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic [4:0]           div_bits;
	logic                 div_busy;
	logic [QUO_W-1:0]     quo;

	assign div_num = cmd.wdiv_start ? DIV_NUM_W'({d_q, 4'd0})
		: ssd_q + DIV_NUM_W'({tw_q, 7'd0});
	assign div_den = cmd.wdiv_start ? DIV_DEN_W'(sigma_eff) : {tw_q, 8'd0};
	assign div_bits = cmd.wdiv_start ? WIDX_BITS : COST_BITS;

	swc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.wdiv_start || cmd.fdiv_start),
		.num    (div_num),
		.den    (div_den),
		.nbits  (div_bits),
		.busy   (div_busy),
		.quo    (quo)
	);

	// per channel difference, truncation and weighting
	weight_t            w_q;
	logic signed [15:0] v0c, v1c, ac;
	logic signed [16:0] dv;
	logic signed [33:0] prod_s1;
	logic signed [34:0] diff;
	logic [33:0]        mag;
	logic [31:0]        limit, mag_q;
	logic [48:0]        mw_q;

	assign v0c = v0_q[ch_q*16 +: 16];
	assign v1c = rd2_q[ch_q*16 +: 16];
	assign ac = rd1_q[ch_q*16 +: 16];
	assign dv = 17'(v1c) - 17'(v0c);
	assign limit = {maxd_q, 16'd0};
	assign diff = $signed({{3{ac[15]}}, ac, 16'd0})
		- ($signed({{3{v0c[15]}}, v0c, 16'd0}) + 35'(prod_s1));
	assign mag = diff[34] ? 34'(-diff) : 34'(diff);

	always_ff @(posedge clk) begin
		if (cmd.w_cap) begin
			w_q <= WEIGHT_LUT[quo[7:0]];
		end
		if (cmd.ch_mul) begin
			prod_s1 <= dv * $signed({1'b0, dst_q[15:0]});
		end
		if (cmd.ch_mag) begin
			mag_q <= (mag > 34'(limit)) ? limit : mag[31:0];
		end
		if (cmd.ch_wmul) begin
			mw_q <= mag_q * w_q;
		end
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ssd_q <= '0;
			tw_q <= '0;
		end else if (cmd.accept) begin
			ssd_q <= '0;
			tw_q <= '0;
		end else if (cmd.ch_acc) begin
			ssd_q <= ssd_q + DIV_NUM_W'(mw_q);
			tw_q <= tw_q + 27'(w_q);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_data.no_support <= (tw_q == 27'd0);
			rsp_data.match_cost <= (tw_q == 27'd0) ? 32'hFFFF_FFFF : 32'(quo);
		end
	end

	// status
	assign st.in_bounds = !px[9] && (px[8:0] < w_eff) && !py[9] && (py[8:0] < h_eff);
	assign st.dst_ok = !dst_q[44] && (dst_q[43:24] == 20'd0) && ({1'b0, ix} < w_eff);
	assign st.w_live = 20'(d_q) < {sigma_eff, 4'd0};
	assign st.div_busy = div_busy;
	assign st.last_chan = ch_q == 2'(CHANNELS - 1);
	assign st.last_pix = (dxc_q == span) && (dyc_q == span);
	assign st.tw_zero = tw_q == 27'd0;

endmodule

// ===== rtl/swc_ctrl.sv =====
// Controller of the match cost unit: walks the window and sequences the datapath.
// Depends on swc_pkg for the state, command and status types.
module swc_ctrl import swc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_type,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  status_t    st,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	logic   out_vq;

	// state and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_vq <= 1'b0;
		end else begin
			state_q <= state_d;
			out_vq <= (out_vq && !rsp_ready) || cmd.out_load;
		end
	end

	assign rsp_valid = out_vq;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					if (req_type == REQ_QUERY) state_d = S_CEN_RD;
				end
			end
			S_CEN_RD: begin
				cmd.centre_rd = 1'b1;
				state_d = S_CEN_CAP;
			end
			S_CEN_CAP: begin
				cmd.centre_cap = 1'b1;
				state_d = S_PIX_RD;
			end
			S_PIX_RD: begin
				if (st.in_bounds) begin
					cmd.pix_rd = 1'b1;
					state_d = S_PIX_EVAL;
				end else begin
					state_d = S_STEP;
				end
			end
			S_PIX_EVAL: begin
				cmd.pix_eval = 1'b1;
				state_d = S_PIX_CHK;
			end
			S_PIX_CHK: begin
				if (st.dst_ok && st.w_live) begin
					cmd.v0_rd = 1'b1;
					cmd.wdiv_start = 1'b1;
					state_d = S_RD_V1;
				end else begin
					state_d = S_STEP;
				end
			end
			S_RD_V1: begin
				cmd.v1_rd = 1'b1;
				state_d = S_WDIV;
			end
			S_WDIV: begin
				if (!st.div_busy) begin
					cmd.w_cap = 1'b1;
					state_d = S_CH_MUL;
				end
			end
			S_CH_MUL: begin
				cmd.ch_mul = 1'b1;
				state_d = S_CH_MAG;
			end
			S_CH_MAG: begin
				cmd.ch_mag = 1'b1;
				state_d = S_CH_WMUL;
			end
			S_CH_WMUL: begin
				cmd.ch_wmul = 1'b1;
				state_d = S_CH_ACC;
			end
			S_CH_ACC: begin
				cmd.ch_acc = 1'b1;
				state_d = st.last_chan ? S_STEP : S_CH_MUL;
			end
			S_STEP: begin
				if (st.last_pix) begin
					state_d = S_FIN;
				end else begin
					cmd.win_step = 1'b1;
					state_d = S_PIX_RD;
				end
			end
			S_FIN: begin
				if (st.tw_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.fdiv_start = 1'b1;
					state_d = S_FDIV;
				end
			end
			S_FDIV: begin
				if (!st.div_busy) state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_vq || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== rtl/slanted_window_weighted_match_cost_unit.sv =====
// Slanted window, color weighted stereo match cost unit.
// Two Lab images are loaded pixel by pixel on the req channel (req_type load first or
// load second); a load is taken in the idle state and gives no result. A query word gives a
// centre pixel and a disparity plane; the unit walks the square window row by row and
// returns one word on rsp: the weighted mean truncated difference in Q16.8, or all
// ones with no_support set when no weight was gathered.
// A query reads and captures the centre pixel, then walks the window. A pixel outside
// the image is skipped; one inside is read and evaluated, and dropped when its target
// column or weight rules it out. A contributing pixel reads two second image pixels,
// waits for the weight index division and takes each channel through interpolation,
// truncated difference, weighting and accumulation; then come the final division, skipped
// with no weight, and the result load. The shared divider and one read port per store set this order.
// One item is in work at a time; req.ready is high only while the unit is idle.
// The result waits in an output register; the unit takes new words while it waits,
// and a following query holds at its end until the pending word is taken.
// Reset clears the control state and restores the default configuration; the image
// stores are not cleared and must be loaded before they are queried. Configuration is
// written through cfg_we/cfg_idx/cfg_data; the user must write it only while idle, as the unit does not check.
// Depends on swc_pkg, swc_req_if, swc_rsp_if, swc_div, swc_dp, swc_ctrl.
module slanted_window_weighted_match_cost_unit import swc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	swc_req_if.sink               req,
	swc_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t st;

	swc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.data.req_type),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	swc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.req_data (req.data),
		.rsp_data (rsp.data),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// no support always reports the all ones cost
	a_nosup_cost: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.no_support |-> rsp.data.match_cost == 32'hFFFF_FFFF)
		else $error("no_support result without all ones cost");

	// a supported cost never exceeds the quotient width
	a_cost_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data.no_support |-> rsp.data.match_cost[31:26] == 6'd0)
		else $error("cost outside quotient range");

	// an accepted query drops req.ready once it has been taken
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.data.req_type == REQ_QUERY |=> !req.ready)
		else $error("request taken during a query");

endmodule
